// ===== rtl/mcg_pkg.sv =====
// ----------------------------------------------------------------------------
// mcg_pkg: shared types and constants of the metronome click generator
// Register widths, register codes, gains and the stage-to-stage structs.
// ----------------------------------------------------------------------------
package mcg_pkg;

  localparam int unsigned BEAT_W     = 26;
  localparam int unsigned CLICK_W    = 13;
  localparam int unsigned BPB_W      = 7;
  localparam int unsigned STEP_W     = 32;
  localparam int unsigned DECAY_W    = 24;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned GAIN_W     = 14;

  // Q15 gains
  localparam logic [GAIN_W-1:0] GAIN_ACCENT = 14'd11141;
  localparam logic [GAIN_W-1:0] GAIN_NORMAL = 14'd7209;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CLICK_ENABLE = 3'd0,
    REG_BEAT_LENGTH  = 3'd1,
    REG_CLICK_LENGTH = 3'd2,
    REG_BEATS_PER_BAR = 3'd3,
    REG_ACCENT_STEP  = 3'd4,
    REG_NORMAL_STEP  = 3'd5,
    REG_DECAY_RATE   = 3'd6
  } cfg_reg_e;

  // divider result handed to the synth pipeline
  typedef struct packed {
    logic [BEAT_W-1:0] offset;
    logic              accent;
    logic              playing;
  } div_res_t;

  // configuration seen by the synth pipeline
  typedef struct packed {
    logic               enable;
    logic [CLICK_W-1:0] click_length;
    logic [STEP_W-1:0]  accent_step;
    logic [STEP_W-1:0]  normal_step;
    logic [DECAY_W-1:0] decay_rate;
  } synth_cfg_t;

endpackage

// ===== rtl/mcg_if.sv =====
// ----------------------------------------------------------------------------
// mcg_if: valid/ready channels of the metronome click generator
// Position input channel and sample output channel.
// ----------------------------------------------------------------------------
interface mcg_in_if #(
  parameter int unsigned POSITION_BITS = 48
);
  logic                     valid;
  logic                     ready;
  logic [POSITION_BITS-1:0] position;
  logic                     playing;

  modport source (output valid, output position, output playing, input ready);
  modport sink   (input valid, input position, input playing, output ready);
endinterface

interface mcg_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [mcg_pkg::SAMPLE_W-1:0] sample_out;
  logic                                in_click;
  logic                                is_accent;

  modport source (output valid, output sample_out, output in_click, output is_accent,
                  input ready);
  modport sink   (input valid, input sample_out, input in_click, input is_accent,
                  output ready);
endinterface

// ===== rtl/mcg_divider.sv =====
// ----------------------------------------------------------------------------
// mcg_divider: pipelined restoring divider
// position / beat_length -> offset; beat mod beats_per_bar tracked per
// quotient bit, so the full quotient is never stored.
// ----------------------------------------------------------------------------
module mcg_divider #(
  parameter int unsigned POSITION_BITS = 48
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic [POSITION_BITS-1:0]       position_i,
  input  logic                           playing_i,
  input  logic [mcg_pkg::BEAT_W-1:0]     beat_length_i,
  input  logic [mcg_pkg::BPB_W-1:0]      beats_per_bar_i,
  output logic                           valid_o,
  output mcg_pkg::div_res_t              res_o
);

  localparam int unsigned BITS_PER_STAGE = 4;
  localparam int unsigned NST  = (POSITION_BITS + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
  localparam int unsigned PADB = NST * BITS_PER_STAGE;
  localparam int unsigned BW   = mcg_pkg::BEAT_W;
  localparam int unsigned MW   = mcg_pkg::BPB_W;

  logic [BW-1:0]   bl_eff;
  logic [MW-1:0]   bpb_eff;
  logic [NST-1:0]  vld_q;
  logic [NST-1:0]  ply_q;
  logic [BW-1:0]   rem_q [NST];
  logic [MW-1:0]   mod_q [NST];
  logic [PADB-1:0] pos_q [NST];

  // zero lengths behave as one
  assign bl_eff  = (beat_length_i == '0) ? BW'(1) : beat_length_i;
  assign bpb_eff = (beats_per_bar_i == '0) ? MW'(1) : beats_per_bar_i;

  for (genvar s = 0; s < NST; s++) begin : g_stage
    logic            src_vld;
    logic            src_ply;
    logic [BW-1:0]   src_rem;
    logic [MW-1:0]   src_mod;
    logic [PADB-1:0] src_pos;
    logic [BW-1:0]   rem_d;
    logic [MW-1:0]   mod_d;

    if (s == 0) begin : g_first
      // leading zero padding leaves quotient and remainder unchanged
      assign src_vld = valid_i;
      assign src_ply = playing_i;
      assign src_rem = '0;
      assign src_mod = '0;
      assign src_pos = PADB'(position_i);
    end else begin : g_next
      assign src_vld = vld_q[s-1];
      assign src_ply = ply_q[s-1];
      assign src_rem = rem_q[s-1];
      assign src_mod = mod_q[s-1];
      assign src_pos = pos_q[s-1];
    end

    always_comb begin : p_step
      logic [BW:0]   r2;
      logic [MW:0]   m2;
      logic          qb;
      logic [BW-1:0] r;
      logic [MW-1:0] m;
      r = src_rem;
      m = src_mod;
      for (int j = 0; j < BITS_PER_STAGE; j++) begin
        r2 = {r, src_pos[PADB - 1 - s * BITS_PER_STAGE - j]};
        qb = (r2 >= {1'b0, bl_eff});
        r  = qb ? BW'(r2 - {1'b0, bl_eff}) : r2[BW-1:0];
        // running quotient mod beats_per_bar
        m2 = {m, qb};
        m  = (m2 >= {1'b0, bpb_eff}) ? MW'(m2 - {1'b0, bpb_eff}) : m2[MW-1:0];
      end
      rem_d = r;
      mod_d = m;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= src_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ply_q[s] <= src_ply;
        rem_q[s] <= rem_d;
        mod_q[s] <= mod_d;
        pos_q[s] <= src_pos;
      end
    end
  end

  assign valid_o        = vld_q[NST-1];
  assign res_o.offset   = rem_q[NST-1];
  assign res_o.accent   = (mod_q[NST-1] == '0);
  assign res_o.playing  = ply_q[NST-1];

endmodule

// ===== rtl/mcg_synth.sv =====
// ----------------------------------------------------------------------------
// mcg_synth: tone and envelope pipeline
// Phase and decay products, sine and exp ROMs, gain and output rounding.
// ----------------------------------------------------------------------------
module mcg_synth #(
  parameter int unsigned SINE_TABLE_BITS = 10,
  parameter int unsigned EXP_TABLE_BITS  = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  mcg_pkg::div_res_t                  res_i,
  input  mcg_pkg::synth_cfg_t                cfg_i,
  output logic                               valid_o,
  output logic signed [mcg_pkg::SAMPLE_W-1:0] sample_o,
  output logic                               in_click_o,
  output logic                               is_accent_o
);

  localparam int unsigned SN  = 1 << SINE_TABLE_BITS;
  localparam int unsigned EN  = 1 << EXP_TABLE_BITS;
  localparam int unsigned BW  = mcg_pkg::BEAT_W;
  localparam int unsigned XW  = mcg_pkg::BEAT_W + mcg_pkg::DECAY_W;
  localparam int unsigned P3W = 32;
  localparam int unsigned P4W = P3W + mcg_pkg::GAIN_W;
  localparam longint unsigned Q30_ONE    = 64'd1 << 30;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef logic [15:0] sine_rom_t [SN+1];
  typedef logic [15:0] env_rom_t [EN];

  // ---------------- elaboration-time table builders ----------------
  // shift-subtract quotient, used only while building the tables
  function automatic longint unsigned cdiv(longint unsigned n, longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      q = {q[62:0], 1'b0};
      if (r >= d) begin
        r    = r - d;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic longint unsigned sin_q30(longint unsigned x);
    longint unsigned sum;
    longint unsigned term;
    sum  = x;
    term = x;
    for (int k = 1; k <= 6; k++) begin
      term = (term * x) >> 30;
      term = cdiv((term * x) >> 30, 64'((2 * k) * (2 * k + 1)));
      if ((k & 1) == 1) sum = (term <= sum) ? sum - term : 64'd0;
      else              sum = sum + term;
    end
    return sum;
  endfunction

  function automatic longint unsigned exp_pos_q30(longint unsigned f);
    longint unsigned sum;
    longint unsigned term;
    sum  = Q30_ONE;
    term = Q30_ONE;
    for (int k = 1; k <= 14; k++) begin
      term = cdiv((term * f) >> 30, 64'(k));
      sum  = sum + term;
    end
    return sum;
  endfunction

  function automatic sine_rom_t build_sine();
    sine_rom_t       t;
    longint unsigned x;
    longint unsigned v;
    for (int i = 0; i <= int'(SN); i++) begin
      x    = (64'(i) * HALF_PI_Q30) >> SINE_TABLE_BITS;
      v    = (sin_q30(x) * 64'd32767 + (64'd1 << 29)) >> 30;
      t[i] = (v > 64'd32767) ? 16'd32767 : 16'(v);
    end
    return t;
  endfunction

  function automatic env_rom_t build_env();
    env_rom_t        t;
    longint unsigned inv_e;
    longint unsigned f;
    longint unsigned v;
    int              fbits;
    int              n;
    fbits = int'(EXP_TABLE_BITS) - 4;
    inv_e = cdiv(64'd1 << 60, exp_pos_q30(Q30_ONE));
    for (int i = 0; i < int'(EN); i++) begin
      n = i >> fbits;
      f = 64'(i & ((1 << fbits) - 1)) << (30 - fbits);
      v = cdiv(64'd1 << 60, exp_pos_q30(f));
      for (int j = 0; j < n; j++) v = (v * inv_e) >> 30;
      v    = (v + (64'd1 << 14)) >> 15;
      t[i] = (v > 64'd32768) ? 16'd32768 : 16'(v);
    end
    return t;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine();
  localparam env_rom_t  ENV_ROM  = build_env();

  // ---------------- stage 1: products ----------------
  logic [mcg_pkg::CLICK_W-1:0] cl_eff;
  logic [mcg_pkg::STEP_W-1:0]  step;
  logic [BW+31:0]              ph_full;
  logic [XW-1:0]               xdec_d;
  logic                        click_d;
  logic                        v1_q, click1_q, acc1_q, act1_q;
  logic [31:0]                 phase1_q;
  logic [XW-1:0]               xdec1_q;

  assign cl_eff  = (cfg_i.click_length == '0) ? mcg_pkg::CLICK_W'(1) : cfg_i.click_length;
  assign step    = res_i.accent ? cfg_i.accent_step : cfg_i.normal_step;
  assign ph_full = (BW+32)'(res_i.offset) * (BW+32)'(step);
  assign xdec_d  = XW'(res_i.offset) * XW'(cfg_i.decay_rate);
  assign click_d = (res_i.offset < BW'(cl_eff));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      click1_q <= click_d;
      acc1_q   <= res_i.accent;
      act1_q   <= click_d & cfg_i.enable & res_i.playing;
      phase1_q <= ph_full[31:0];
      xdec1_q  <= xdec_d;
    end
  end

  // ---------------- stage 2: ROM reads ----------------
  logic [1:0]                 quad;
  logic [SINE_TABLE_BITS-1:0] idx;
  logic [SINE_TABLE_BITS:0]   sidx;
  logic                       eovf;
  logic [EXP_TABLE_BITS-1:0]  eidx;
  logic                       v2_q, click2_q, acc2_q, act2_q, neg2_q;
  logic [15:0]                sin2_q, env2_q;

  assign quad = phase1_q[31:30];
  assign idx  = phase1_q[29 -: SINE_TABLE_BITS];
  assign sidx = quad[0] ? (SINE_TABLE_BITS+1)'(SN) - {1'b0, idx} : {1'b0, idx};
  // envelope saturates to zero once x reaches 16
  assign eovf = (xdec1_q[XW-1:28] != '0);
  assign eidx = xdec1_q[27 -: EXP_TABLE_BITS];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      click2_q <= click1_q;
      acc2_q   <= acc1_q;
      act2_q   <= act1_q;
      neg2_q   <= quad[1];
      sin2_q   <= SINE_ROM[sidx];
      env2_q   <= eovf ? 16'd0 : ENV_ROM[eidx];
    end
  end

  // ---------------- stage 3: sine * envelope ----------------
  logic           v3_q, click3_q, acc3_q, act3_q, neg3_q;
  logic [P3W-1:0] prod3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      click3_q <= click2_q;
      acc3_q   <= acc2_q;
      act3_q   <= act2_q;
      neg3_q   <= neg2_q;
      prod3_q  <= P3W'(sin2_q) * P3W'(env2_q);
    end
  end

  // ---------------- stage 4: gain ----------------
  logic [mcg_pkg::GAIN_W-1:0] gain;
  logic                       v4_q, click4_q, acc4_q, act4_q, neg4_q;
  logic [P4W-1:0]             prod4_q;

  assign gain = acc3_q ? mcg_pkg::GAIN_ACCENT : mcg_pkg::GAIN_NORMAL;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      click4_q <= click3_q;
      acc4_q   <= acc3_q;
      act4_q   <= act3_q;
      neg4_q   <= neg3_q;
      prod4_q  <= P4W'(prod3_q) * P4W'(gain);
    end
  end

  // ---------------- stage 5: round, sign, saturate ----------------
  logic [P4W:0]                         rnd;
  logic [P4W-30:0]                      mag_full;
  logic [15:0]                          mag;
  logic signed [mcg_pkg::SAMPLE_W-1:0]  sample_d;
  logic                                 v5_q, click5_q, acc5_q;
  logic signed [mcg_pkg::SAMPLE_W-1:0]  sample5_q;

  assign rnd      = {1'b0, prod4_q} + (P4W+1)'(64'd1 << 29);
  assign mag_full = rnd[P4W:30];
  assign mag      = (mag_full > (P4W-29)'(32768)) ? 16'd32768 : mag_full[15:0];

  always_comb begin
    if (!act4_q) begin
      sample_d = '0;
    end else if (neg4_q) begin
      sample_d = -$signed(mag);
    end else if (mag == 16'd32768) begin
      sample_d = 16'sd32767;
    end else begin
      sample_d = $signed(mag);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      click5_q  <= click4_q;
      acc5_q    <= acc4_q;
      sample5_q <= sample_d;
    end
  end

  // valid bits per stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  assign valid_o     = v5_q;
  assign sample_o    = sample5_q;
  assign in_click_o  = click5_q;
  assign is_accent_o = acc5_q;

  // ---------------- assertions ----------------
  a_silent_outside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v5_q && (sample5_q != '0) |-> click5_q)
    else $error("sample outside click window");

  a_env_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && v1_q && eovf |=> env2_q == 16'd0)
    else $error("envelope not saturated");

  a_gain_normal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v5_q && !acc5_q |-> (sample5_q <= 16'sd7209) && (sample5_q >= -16'sd7209))
    else $error("normal beat exceeds normal gain");

  a_gain_accent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v5_q |-> (sample5_q <= 16'sd11141) && (sample5_q >= -16'sd11141))
    else $error("sample exceeds accent gain");

endmodule

// ===== rtl/metronome_click_generator_top.sv =====
// ----------------------------------------------------------------------------
// metronome_click_generator_top: metronome click sample generator
// One transport position in, one Q1.15 click sample out.
// ----------------------------------------------------------------------------
// Usage:
//  in_ch  carries position (sample index) and playing; one transfer per
//         output sample.
//  out_ch carries sample_out, in_click and is_accent for that position, in
//         order, one transfer per input transfer.
//  cfg    plain write port (cfg_we_i, cfg_idx_i, cfg_data_i); write only when
//         the pipeline is empty. Index 7 is ignored.
//  Pipeline: the divider retires four quotient bits per stage; five more
//         stages form the phase/decay products, read the ROMs, apply
//         envelope and gain and round.
//  Throughput: one transfer per cycle in both directions when not stalled.
//  Stall: the whole pipeline holds while the output register is full and
//         out_ch.ready is low; in_ch.ready follows that hold.
//  Reset: valid bits clear, registers take their documented defaults
//         (clicks disabled, 24000-sample beats, 4/4).
// ----------------------------------------------------------------------------
module metronome_click_generator_top #(
  parameter int unsigned POSITION_BITS   = 48,
  parameter int unsigned SINE_TABLE_BITS = 10,
  parameter int unsigned EXP_TABLE_BITS  = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  mcg_in_if.sink                             in_ch,
  mcg_out_if.source                          out_ch,
  input  logic                               cfg_we_i,
  input  logic [mcg_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [mcg_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  // register file
  logic                         click_enable_q;
  logic [mcg_pkg::BEAT_W-1:0]   beat_length_q;
  logic [mcg_pkg::CLICK_W-1:0]  click_length_q;
  logic [mcg_pkg::BPB_W-1:0]    beats_per_bar_q;
  logic [mcg_pkg::STEP_W-1:0]   accent_step_q;
  logic [mcg_pkg::STEP_W-1:0]   normal_step_q;
  logic [mcg_pkg::DECAY_W-1:0]  decay_rate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      click_enable_q  <= 1'b0;
      beat_length_q   <= 26'd24000;
      click_length_q  <= 13'd1680;
      beats_per_bar_q <= 7'd4;
      accent_step_q   <= 32'd157482135;
      normal_step_q   <= 32'd107374182;
      decay_rate_q    <= 24'd33204;
    end else if (cfg_we_i) begin
      unique case (mcg_pkg::cfg_reg_e'(cfg_idx_i))
        mcg_pkg::REG_CLICK_ENABLE:  click_enable_q  <= cfg_data_i[0];
        mcg_pkg::REG_BEAT_LENGTH:   beat_length_q   <= cfg_data_i[mcg_pkg::BEAT_W-1:0];
        mcg_pkg::REG_CLICK_LENGTH:  click_length_q  <= cfg_data_i[mcg_pkg::CLICK_W-1:0];
        mcg_pkg::REG_BEATS_PER_BAR: beats_per_bar_q <= cfg_data_i[mcg_pkg::BPB_W-1:0];
        mcg_pkg::REG_ACCENT_STEP:   accent_step_q   <= cfg_data_i;
        mcg_pkg::REG_NORMAL_STEP:   normal_step_q   <= cfg_data_i;
        mcg_pkg::REG_DECAY_RATE:    decay_rate_q    <= cfg_data_i[mcg_pkg::DECAY_W-1:0];
        default: ;
      endcase
    end
  end

  // global pipeline advance: output register empty or being drained
  logic                out_vld;
  logic                en;
  logic                div_vld;
  mcg_pkg::div_res_t   div_res;
  mcg_pkg::synth_cfg_t syn_cfg;

  assign en          = !out_vld || out_ch.ready;
  assign in_ch.ready = en;

  assign syn_cfg.enable       = click_enable_q;
  assign syn_cfg.click_length = click_length_q;
  assign syn_cfg.accent_step  = accent_step_q;
  assign syn_cfg.normal_step  = normal_step_q;
  assign syn_cfg.decay_rate   = decay_rate_q;

  // beat / offset split
  mcg_divider #(
    .POSITION_BITS (POSITION_BITS)
  ) u_div (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (en),
    .valid_i         (in_ch.valid),
    .position_i      (in_ch.position),
    .playing_i       (in_ch.playing),
    .beat_length_i   (beat_length_q),
    .beats_per_bar_i (beats_per_bar_q),
    .valid_o         (div_vld),
    .res_o           (div_res)
  );

  // tone, envelope, gain; last stage is the output register
  mcg_synth #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS),
    .EXP_TABLE_BITS  (EXP_TABLE_BITS)
  ) u_synth (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (div_vld),
    .res_i       (div_res),
    .cfg_i       (syn_cfg),
    .valid_o     (out_vld),
    .sample_o    (out_ch.sample_out),
    .in_click_o  (out_ch.in_click),
    .is_accent_o (out_ch.is_accent)
  );

  assign out_ch.valid = out_vld;

endmodule
